>>> hw/rtl/rlmt_pkg.sv
// Package with the shared widths and constants of the run length merge tracker.
`default_nettype none

package rlmt_pkg;

	// Widths of the fixed transaction fields.
	localparam int POS_W     = 11;
	localparam int LEN_CFG_W = 11;
	localparam int STEP_W    = 11;

	// Default number of tracked positions.
	localparam int NUM_POSITIONS_DEF = 1024;

	// The step counter stops at its largest value.
	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	// Target length after reset.
	localparam logic [LEN_CFG_W-1:0] TARGET_LEN_RST = LEN_CFG_W'(1);

endpackage

`default_nettype wire

>>> hw/rtl/rlmt_ifs.sv
// Valid/ready channel interfaces for the request, result and configuration transactions.
`default_nettype none

interface rlmt_req_if;
	logic                          valid;
	logic                          ready;
	logic [rlmt_pkg::POS_W-1:0]    position;

	modport source (output valid, output position, input ready);
	modport sink   (input valid, input position, output ready);
endinterface

interface rlmt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          target_present;
	logic [rlmt_pkg::STEP_W-1:0]   latest_step;
	logic                          repeat_ignored;

	modport source (output valid, output target_present, output latest_step,
		output repeat_ignored, input ready);
	modport sink   (input valid, input target_present, input latest_step,
		input repeat_ignored, output ready);
endinterface

interface rlmt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rlmt_pkg::LEN_CFG_W-1:0]  target_len;

	modport source (output valid, output target_len, input ready);
	modport sink   (input valid, input target_len, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/run_length_merge_tracker_core.sv
// Top level of the run length merge tracker: memories, merge pipeline and result buffer.
//
//  channel | dir | payload                                      | transaction
//  --------+-----+----------------------------------------------+---------------------------
//  req     | in  | position                                     | one position to set
//  rsp     | out | target_present, latest_step, repeat_ignored  | one result per request
//  cfg     | in  | target_len                                   | write of the target length
//
// No request is accepted while stage 1 is busy: the second run endpoint is written back
// through the length memory's single write port in the cycle after the merge.
// A result goes from stage 1 to the output register, or to the skid register on a stall.
// After reset a clearing pass zeroes every cell; requests wait, cfg writes do not.
// A stalled result sits in the output register and a second one in the skid register;
// requests are accepted while the output register holds an untaken result.
`default_nettype none

module run_length_merge_tracker_core #(
	parameter int NUM_POSITIONS = rlmt_pkg::NUM_POSITIONS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	rlmt_req_if.sink     req,
	rlmt_rsp_if.source   rsp,
	rlmt_cfg_if.sink     cfg
);

	localparam int ADDR_W = $clog2(NUM_POSITIONS);
	localparam int LEN_W  = $clog2(NUM_POSITIONS + 1);
	localparam int POS_W  = rlmt_pkg::POS_W;
	localparam int STEP_W = rlmt_pkg::STEP_W;

	// Run lengths, valid at the two end cells of every run; zero at cells never set.
	logic [LEN_W-1:0] len_mem [NUM_POSITIONS];
	// One flag per cell that says whether the cell has been set.
	logic             set_mem [NUM_POSITIONS];

	// ------------------------------------------------------------------
	// Request decode. The position is checked and turned into a 0-based
	// index, and the addresses of both neighbors are formed. A neighbor
	// that falls off the row reads the cell itself and is masked later.
	// ------------------------------------------------------------------
	logic              accept;
	logic              in_range;
	logic [POS_W-1:0]  pos_m1;
	logic [ADDR_W-1:0] idx;
	logic              has_left;
	logic              has_right;
	logic [ADDR_W-1:0] addr_l;
	logic [ADDR_W-1:0] addr_r;

	// Control registers.
	logic                            valid_s1;
	logic                            wb_pend_s2;
	logic                            clr_busy_q;
	logic [ADDR_W-1:0]               clr_addr_q;
	logic [rlmt_pkg::LEN_CFG_W-1:0]  target_len_q;
	logic [LEN_W-1:0]                cnt_q;
	logic [STEP_W-1:0]               step_q;
	logic [STEP_W-1:0]               latest_q;
	logic                            out_valid_q;
	logic                            skid_valid_q;

	// Stage 1 payload and memory read data.
	logic [ADDR_W-1:0] idx_s1;
	logic              in_range_s1;
	logic              has_left_s1;
	logic              has_right_s1;
	logic              fwd_l_s1;
	logic              fwd_r_s1;
	logic [LEN_W-1:0]  rd_left_s1;
	logic [LEN_W-1:0]  rd_right_s1;
	logic              rd_set_s1;

	// Second endpoint write, held for the write-back after the merge.
	logic [ADDR_W-1:0] b_addr_s2;
	logic [LEN_W-1:0]  total_s2;

	// Output and skid registers.
	logic              out_present_q;
	logic [STEP_W-1:0] out_latest_q;
	logic              out_ignored_q;
	logic              skid_present_q;
	logic [STEP_W-1:0] skid_latest_q;
	logic              skid_ignored_q;

	assign req.ready = !clr_busy_q && !valid_s1 && !skid_valid_q;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		in_range  = (req.position != '0) && (32'(req.position) <= 32'(NUM_POSITIONS));
		pos_m1    = req.position - POS_W'(1);
		idx       = in_range ? ADDR_W'(pos_m1) : '0;
		has_left  = idx != '0;
		has_right = idx != ADDR_W'(NUM_POSITIONS - 1);
		addr_l    = has_left ? idx - ADDR_W'(1) : idx;
		addr_r    = has_right ? idx + ADDR_W'(1) : idx;
	end

	// ------------------------------------------------------------------
	// Stage 1: merge. The neighbor lengths come from the memory, or from
	// the endpoint write of the previous request when it lands in the
	// same edge as this request's read.
	// ------------------------------------------------------------------
	logic [LEN_W-1:0]  left;
	logic [LEN_W-1:0]  right;
	logic              ignored;
	logic [LEN_W-1:0]  total;
	logic [LEN_W-1:0]  a_ext;
	logic [LEN_W-1:0]  b_ext;
	logic              dec_l;
	logic              dec_r;
	logic              inc;
	logic [LEN_W-1:0]  cnt_a;
	logic [LEN_W-1:0]  cnt_b;
	logic [LEN_W-1:0]  cnt_c;
	logic [LEN_W-1:0]  cnt_upd;
	logic [STEP_W-1:0] step_nx;
	logic [STEP_W-1:0] latest_nx;
	logic              present_nx;

	always_comb begin
		left    = has_left_s1 ? (fwd_l_s1 ? total_s2 : rd_left_s1) : '0;
		right   = has_right_s1 ? (fwd_r_s1 ? total_s2 : rd_right_s1) : '0;
		ignored = !in_range_s1 || rd_set_s1;
		total   = left + right + LEN_W'(1);
		a_ext   = LEN_W'(idx_s1) - left;
		b_ext   = LEN_W'(idx_s1) + right;

		// Runs that disappear into the merged run leave the target count.
		dec_l = (left != '0) && (32'(left) == 32'(target_len_q));
		dec_r = (right != '0) && (32'(right) == 32'(target_len_q));
		inc   = 32'(total) == 32'(target_len_q);
		cnt_a = (dec_l && cnt_q != '0) ? cnt_q - LEN_W'(1) : cnt_q;
		cnt_b = (dec_r && cnt_a != '0) ? cnt_a - LEN_W'(1) : cnt_a;
		cnt_c = inc ? cnt_b + LEN_W'(1) : cnt_b;
		cnt_upd = ignored ? cnt_q : cnt_c;

		step_nx    = (step_q == rlmt_pkg::STEP_MAX) ? step_q : step_q + STEP_W'(1);
		present_nx = cnt_upd != '0;
		latest_nx  = present_nx ? step_nx : latest_q;
	end

	// ------------------------------------------------------------------
	// Memory write ports. The clearing pass owns them after reset. A set
	// request writes its first endpoint and its set flag in stage 1 and
	// its second endpoint in the following cycle.
	// ------------------------------------------------------------------
	logic              len_we;
	logic [ADDR_W-1:0] len_waddr;
	logic [LEN_W-1:0]  len_wdata;
	logic              set_we;
	logic [ADDR_W-1:0] set_waddr;
	logic              set_wdata;

	always_comb begin
		len_we    = 1'b0;
		len_waddr = b_addr_s2;
		len_wdata = total_s2;
		set_we    = 1'b0;
		set_waddr = idx_s1;
		set_wdata = 1'b1;
		if (clr_busy_q) begin
			len_we    = 1'b1;
			len_waddr = clr_addr_q;
			len_wdata = '0;
			set_we    = 1'b1;
			set_waddr = clr_addr_q;
			set_wdata = 1'b0;
		end else if (valid_s1 && !ignored) begin
			len_we    = 1'b1;
			len_waddr = a_ext[ADDR_W-1:0];
			len_wdata = total;
			set_we    = 1'b1;
		end else if (wb_pend_s2) begin
			len_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (set_we) begin
			set_mem[set_waddr] <= set_wdata;
		end
		rd_left_s1  <= len_mem[addr_l];
		rd_right_s1 <= len_mem[addr_r];
		rd_set_s1   <= set_mem[idx];
	end

	// Request payload into stage 1, with the forwarding decision taken at the read edge.
	always_ff @(posedge clk) begin
		idx_s1       <= idx;
		in_range_s1  <= in_range;
		has_left_s1  <= has_left;
		has_right_s1 <= has_right;
		fwd_l_s1     <= wb_pend_s2 && (addr_l == b_addr_s2);
		fwd_r_s1     <= wb_pend_s2 && (addr_r == b_addr_s2);
		if (valid_s1) begin
			b_addr_s2 <= b_ext[ADDR_W-1:0];
			total_s2  <= total;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			wb_pend_s2   <= 1'b0;
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			target_len_q <= rlmt_pkg::TARGET_LEN_RST;
			cnt_q        <= '0;
			step_q       <= '0;
			latest_q     <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			valid_s1   <= accept;
			wb_pend_s2 <= valid_s1 && !ignored;

			if (clr_busy_q) begin
				if (clr_addr_q == ADDR_W'(NUM_POSITIONS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end

			if (cfg.valid) begin
				target_len_q <= cfg.target_len;
			end

			if (valid_s1) begin
				cnt_q    <= cnt_upd;
				step_q   <= step_nx;
				latest_q <= latest_nx;
			end

			// The skid register is always empty when a new result arrives.
			if (valid_s1) begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_valid_q && rsp.ready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && (!out_valid_q || rsp.ready)) begin
			out_present_q <= present_nx;
			out_latest_q  <= latest_nx;
			out_ignored_q <= ignored;
		end else if (valid_s1) begin
			skid_present_q <= present_nx;
			skid_latest_q  <= latest_nx;
			skid_ignored_q <= ignored;
		end else if (out_valid_q && rsp.ready && skid_valid_q) begin
			out_present_q <= skid_present_q;
			out_latest_q  <= skid_latest_q;
			out_ignored_q <= skid_ignored_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.target_present = out_present_q;
	assign rsp.latest_step    = out_latest_q;
	assign rsp.repeat_ignored = out_ignored_q;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> out_valid_q)
		else $error("merged request left no result in the output register");

	a_write_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && wb_pend_s2))
		else $error("merge and endpoint write-back compete for the length memory");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != $past(step_q)) |-> (step_q == STEP_W'($past(step_q) + 1'b1)))
		else $error("step counter moved by other than one");

	a_present_has_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.target_present) |-> (rsp.latest_step != '0))
		else $error("target reported present without a step");
`endif

endmodule

`default_nettype wire
